### sv/osb_pkg.sv
`default_nettype none
package osb_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_ALLOC = 3'd0,
    MODE_FREE  = 3'd1,
    MODE_SINE  = 3'd2,
    MODE_SAW   = 3'd3,
    MODE_TICK  = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SINE = 2'd1,
    KIND_SAW  = 2'd2
  } kind_t;

  // One slot's record, as held in the slot memory.
  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  phase;
    logic [DATA_W-1:0]  offset;
    logic [DATA_W-1:0]  ampl;
    logic [DATA_W-1:0]  period;
  } slot_rec_t;

  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598668;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026995;
  localparam logic [63:0] POLY_C9 = 64'd172272;

  // Quarter-wave sine sample in Q1.15; used only at elaboration time to fill the table.
  function automatic logic [15:0] quarter_sine(input int unsigned r, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    x  = 64'(r) << (32 - tbits);
    x2 = (x * x) >> 30;
    p  = POLY_C9;
    p  = POLY_C7 - ((x2 * p) >> 30);
    p  = POLY_C5 - ((x2 * p) >> 30);
    p  = POLY_C3 - ((x2 * p) >> 30);
    p  = POLY_C1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[15:0];
  endfunction

  function automatic logic signed [16:0] sine_entry(input int unsigned k, input int unsigned tbits);
    int unsigned qb;
    int unsigned q;
    int unsigned r;
    logic [15:0] m;
    qb = tbits - 2;
    q  = (k >> qb) & 3;
    r  = k & ((1 << qb) - 1);
    if ((q & 1) != 0) r = (1 << qb) - r;
    m = quarter_sine(r, tbits);
    return ((q & 2) != 0) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage
`default_nettype wire

### sv/oscillator_slot_bank_top.sv
`default_nettype none
// Alloc, free and read step through S_RD, S_DECIDE and S_OUT before offering their result; play
// runs one restoring division of 64 quotient bits through a one-bit-per-cycle divider, none for
// a zero period. Tick walks every slot and recomputes each one in use the same way; when its
// phase wraps, the modulo takes its own pass through the divider first. Idle slots are skipped.
// Reset (rst, synchronous): free stack reloads and all slot records read as zero through
// per-slot valid bits; the free stack is refilled by a clearing pass over all POOL_SLOTS entries.
module oscillator_slot_bank_top
  import osb_pkg::*;
#(
  parameter int unsigned POOL_SLOTS      = 64,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               mode,
  input  wire logic [7:0]               slot_index,
  input  wire logic signed [31:0]       shift_in,
  input  wire logic signed [31:0]       ampl_in,
  input  wire logic [31:0]              period_in,
  input  wire logic [31:0]              dt,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    status,
  output logic [7:0]                    granted_slot,
  output logic signed [31:0]            wave_value
);

  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned TAB = 1 << SINE_TABLE_BITS;
  localparam int unsigned DIVW = 64;
  localparam logic [8:0] SLOT_LIMIT = 9'(POOL_SLOTS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_DECIDE, S_MOD, S_MODFIN, S_DIVSET, S_DIV, S_TAB, S_MUL, S_ADD,
    S_WRITE, S_OUT, S_TNEXT
  } state_t;

  // Slot memory and value memory, one synchronous port each.
  slot_rec_t          slot_mem [POOL_SLOTS];
  logic [31:0]        val_mem  [POOL_SLOTS];
  logic [SW-1:0]      stack_mem[POOL_SLOTS];
  logic [POOL_SLOTS-1:0] in_use;
  logic [POOL_SLOTS-1:0] rec_ok;
  logic [POOL_SLOTS-1:0] val_ok;

  // The sine table is a constant array built at elaboration and read through a register.
  logic signed [16:0] sine_rom [TAB];
  logic signed [16:0] rd_tab;

  initial begin
    for (int unsigned k = 0; k < TAB; k++) sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  state_t       state;
  logic [CW-1:0] free_count;
  logic [SW-1:0] clr_ptr;
  logic [SW-1:0] addr;
  logic [2:0]    cur_mode;
  logic [7:0]    req_slot;
  logic [31:0]   req_shift, req_ampl, req_period, req_dt;

  slot_rec_t    rd_rec;
  logic [31:0]  rd_val;
  logic [SW-1:0] rd_stack;
  logic         rd_rec_ok, rd_val_ok;

  slot_rec_t    rec;
  logic [31:0]  new_value;

  // Shared restoring divider.
  logic [DIVW-1:0] dv_num;
  logic [32:0]     dv_rem;
  logic [31:0]     dv_den;
  logic [6:0]      dv_cnt;
  logic            div_is_mod;
  logic            div_neg;

  logic signed [63:0] prod;
  logic signed [63:0] term;

  logic [1:0]  res_status;
  logic [7:0]  res_grant;
  logic [31:0] res_wave;

  logic        tick_mode;
  logic [32:0] sum33;
  logic [32:0] rem_try;
  logic [31:0] abs_ampl;
  logic [63:0] saw_num;
  logic signed [63:0] sum_val;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign tick_mode = (cur_mode == MODE_TICK);
  assign rem_try   = {dv_rem[31:0], dv_num[DIVW-1]} - {1'b0, dv_den};
  assign abs_ampl  = rec.ampl[31] ? (~rec.ampl + 32'd1) : rec.ampl;
  assign saw_num   = 64'(abs_ampl) * 64'(rec.phase);
  assign sum_val   = 64'($signed(rec.offset)) + term;
  assign new_value = sat32(sum_val);

  // Memory reads, registered.
  always_ff @(posedge clk) begin
    rd_rec    <= slot_mem[addr];
    rd_val    <= val_mem[addr];
    rd_stack  <= stack_mem[SW'(free_count - CW'(1))];
    rd_rec_ok <= rec_ok[addr];
    rd_val_ok <= val_ok[addr];
    rd_tab    <= sine_rom[dv_num[SINE_TABLE_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      stack_mem[clr_ptr] <= SW'(POOL_SLOTS - 1) - clr_ptr;
    end else if (state == S_OUT && cur_mode == MODE_FREE && res_status == ST_OK) begin
      stack_mem[SW'(free_count)] <= req_slot[SW-1:0];
    end
    if (state == S_WRITE) begin
      slot_mem[addr] <= rec;
      if (rec.kind != KIND_NONE) val_mem[addr] <= new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      free_count <= CW'(POOL_SLOTS);
      in_use     <= '0;
      rec_ok     <= '0;
      val_ok     <= '0;
      out_valid  <= 1'b0;
      addr       <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + SW'(1);
          if (clr_ptr == SW'(POOL_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_mode   <= mode;
            req_slot   <= slot_index;
            req_shift  <= shift_in;
            req_ampl   <= ampl_in;
            req_period <= period_in;
            req_dt     <= dt;
            res_status <= ST_OK;
            res_grant  <= '0;
            res_wave   <= '0;
            addr       <= (mode == MODE_TICK) ? SW'(0) : slot_index[SW-1:0];
            state      <= S_RD;
          end
        end
        S_RD: state <= S_DECIDE;
        S_DECIDE: begin
          unique case (cur_mode)
            MODE_ALLOC: begin
              if (free_count == '0) res_status <= ST_NO_FREE;
              else begin
                free_count <= free_count - CW'(1);
                res_grant  <= 8'(rd_stack);
                in_use[rd_stack] <= 1'b1;
              end
              state <= S_OUT;
            end
            MODE_FREE: begin
              if ({1'b0, req_slot} >= SLOT_LIMIT || !in_use[addr]) res_status <= ST_BAD;
              else in_use[addr] <= 1'b0;
              state <= S_OUT;
            end
            MODE_SINE, MODE_SAW: begin
              if ({1'b0, req_slot} >= SLOT_LIMIT) begin
                res_status <= ST_BAD;
                state <= S_OUT;
              end else begin
                rec <= '{kind_t'((cur_mode == MODE_SINE) ? KIND_SINE : KIND_SAW), 32'd0,
                         req_shift, req_ampl, req_period};
                state <= S_DIVSET;
              end
            end
            MODE_TICK: begin
              if (!in_use[addr]) state <= S_TNEXT;
              else begin
                rec   <= rd_rec_ok ? rd_rec : '0;
                sum33 <= 33'(rd_rec_ok ? rd_rec.phase : 32'd0) + 33'(req_dt);
                state <= S_MOD;
              end
            end
            MODE_READ: begin
              if ({1'b0, req_slot} >= SLOT_LIMIT) res_status <= ST_BAD;
              else res_wave <= rd_val_ok ? rd_val : 32'd0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_MOD: begin
          if (rec.period == '0) begin
            rec.phase <= sum33[31:0];
            state <= S_DIVSET;
          end else if (sum33 > 33'(rec.period)) begin
            dv_num <= {31'd0, sum33};
            dv_den <= rec.period;
            dv_rem <= '0;
            dv_cnt <= 7'(DIVW);
            div_is_mod <= 1'b1;
            state <= S_DIV;
          end else begin
            rec.phase <= sum33[31:0];
            state <= S_DIVSET;
          end
        end
        S_MODFIN: begin
          rec.phase <= (dv_rem[31:0] == '0) ? rec.period : dv_rem[31:0];
          state <= S_DIVSET;
        end
        S_DIVSET: begin
          div_is_mod <= 1'b0;
          dv_den <= rec.period;
          dv_rem <= '0;
          dv_cnt <= 7'(DIVW);
          div_neg <= rec.ampl[31] && (rec.phase != '0);
          if (rec.kind == KIND_NONE) state <= S_WRITE;
          else if (rec.period == '0) begin
            term <= '0;
            state <= S_ADD;
          end else begin
            dv_num <= (rec.kind == KIND_SINE) ? (64'(rec.phase) << SINE_TABLE_BITS) : saw_num;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!rem_try[32]) dv_rem <= rem_try;
          else dv_rem <= {dv_rem[31:0], dv_num[DIVW-1]};
          dv_num <= {dv_num[DIVW-2:0], ~rem_try[32]};
          dv_cnt <= dv_cnt - 7'd1;
          if (dv_cnt == 7'd1) state <= div_is_mod ? S_MODFIN : S_TAB;
        end
        // The table entry for the finished quotient is fetched in this cycle.
        S_TAB: state <= S_MUL;
        S_MUL: begin
          if (rec.kind == KIND_SINE) begin
            prod <= 64'($signed(rec.ampl)) * 64'(rd_tab) + 64'sd16384;
          end else begin
            prod <= div_neg ? -$signed(dv_num) : $signed(dv_num);
          end
          state <= S_ADD;
          term <= '0;
        end
        S_ADD: begin
          if (rec.kind == KIND_SINE && rec.period != '0) term <= prod >>> 15;
          else if (rec.period != '0) begin
            if (!div_neg && dv_num[63:31] != '0) term <= 64'sd2147483647;
            else if (div_neg && dv_num > 64'd2147483648) term <= -64'sd2147483648;
            else term <= prod;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (rec.kind != KIND_NONE) begin
            val_ok[addr] <= 1'b1;
          end
          rec_ok[addr] <= 1'b1;
          state <= tick_mode ? S_TNEXT : S_OUT;
        end
        S_TNEXT: begin
          if (addr == SW'(POOL_SLOTS - 1)) state <= S_OUT;
          else begin
            addr <= addr + SW'(1);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            granted_slot <= res_grant;
            wave_value   <= res_wave;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (cur_mode == MODE_FREE && res_status == ST_OK) free_count <= free_count + CW'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(POOL_SLOTS)) else $error("free count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import osb_pkg::*;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned TBITS = 10;
  localparam int unsigned TSIZE = 1 << TBITS;
  localparam int unsigned WATCHDOG_LIMIT = 60000;

  // One command as offered to the block.
  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  slot;
    logic [31:0] shift;
    logic [31:0] ampl;
    logic [31:0] period;
    logic [31:0] dt;
  } command_t;

  // One expected answer.
  typedef struct {
    logic [1:0]  status;
    logic [7:0]  granted;
    logic [31:0] wave;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] mode = '0;
  logic [7:0] slot_index = '0;
  logic signed [31:0] shift_in = '0;
  logic signed [31:0] ampl_in = '0;
  logic [31:0] period_in = '0;
  logic [31:0] dt = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] status;
  logic [7:0] granted_slot;
  logic signed [31:0] wave_value;

  oscillator_slot_bank_top #(.POOL_SLOTS(SLOTS), .SINE_TABLE_BITS(TBITS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .slot_index(slot_index), .shift_in(shift_in), .ampl_in(ampl_in),
    .period_in(period_in), .dt(dt),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .granted_slot(granted_slot), .wave_value(wave_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the slot pool that predicts every answer.
  logic signed [31:0] sine_lut [TSIZE];
  logic [7:0]  shadow_stack [SLOTS];
  int unsigned shadow_count;
  logic        shadow_used [SLOTS];
  kind_t       shadow_kind [SLOTS];
  logic [31:0] shadow_phase [SLOTS];
  logic signed [31:0] shadow_offset [SLOTS];
  logic signed [31:0] shadow_ampl [SLOTS];
  logic [31:0] shadow_period [SLOTS];
  logic signed [31:0] shadow_value [SLOTS];

  command_t pending_cmds[$];
  answer_t  expected_answers[$];
  int unsigned error_count = 0;
  bit stimulus_done = 1'b0;
  bit hold_receiver = 1'b0;

  // Sine table built independently: odd Taylor polynomial in Q30, rounded to Q1.15.
  function automatic logic signed [31:0] quarter_wave(int unsigned r);
    logic [63:0] x, x2, p, s;
    x  = 64'(r) << (32 - TBITS);
    x2 = (x * x) >> 30;
    p  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return $signed({16'd0, s[15:0]});
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Recomputes the stored value of one slot from its phase and waveform.
  function automatic void refresh_value(int unsigned s);
    longint term, prod;
    logic [63:0] idx;
    if (shadow_kind[s] == KIND_NONE) return;
    if (shadow_period[s] == 0) begin
      term = 0;
    end else if (shadow_kind[s] == KIND_SINE) begin
      idx = ({32'd0, shadow_phase[s]} << TBITS) / {32'd0, shadow_period[s]};
      prod = longint'(shadow_ampl[s]) * longint'(sine_lut[idx[TBITS-1:0]]) + 16384;
      term = (prod >= 0) ? (prod >>> 15) : -(((-prod) + 32767) >>> 15);
    end else begin
      // Signed division truncates toward zero, as required.
      term = clamp32((longint'(shadow_ampl[s]) * longint'({32'd0, shadow_phase[s]}))
                     / longint'({32'd0, shadow_period[s]}));
    end
    shadow_value[s] = 32'(clamp32(longint'(shadow_offset[s]) + term));
  endfunction

  function automatic void pool_reset();
    int unsigned k, q, r;
    logic signed [31:0] m;
    for (k = 0; k < TSIZE; k++) begin
      q = (k >> (TBITS - 2)) & 3;
      r = k & ((1 << (TBITS - 2)) - 1);
      if (q & 1) r = (1 << (TBITS - 2)) - r;
      m = quarter_wave(r);
      sine_lut[k] = (q & 2) ? -m : m;
    end
    for (k = 0; k < SLOTS; k++) begin
      shadow_stack[k] = 8'(SLOTS - 1 - k);
      shadow_used[k] = 1'b0;
      shadow_kind[k] = KIND_NONE;
      shadow_phase[k] = '0;
      shadow_offset[k] = '0;
      shadow_ampl[k] = '0;
      shadow_period[k] = '0;
      shadow_value[k] = '0;
    end
    shadow_count = SLOTS;
  endfunction

  // Applies one accepted command to the shadow pool and returns the answer it earns.
  function automatic answer_t pool_apply(command_t c);
    answer_t a;
    bit ok;
    logic [32:0] sum;
    a = '{ST_OK, 8'd0, 32'd0};
    ok = c.slot < SLOTS;
    case (c.mode)
      MODE_ALLOC: begin
        if (shadow_count == 0) begin
          a.status = ST_NO_FREE;
        end else begin
          shadow_count--;
          a.granted = shadow_stack[shadow_count];
          shadow_used[a.granted] = 1'b1;
        end
      end
      MODE_FREE: begin
        if (!ok || !shadow_used[c.slot]) begin
          a.status = ST_BAD;
        end else begin
          shadow_used[c.slot] = 1'b0;
          shadow_stack[shadow_count] = c.slot;
          shadow_count++;
        end
      end
      MODE_SINE, MODE_SAW: begin
        if (!ok) begin
          a.status = ST_BAD;
        end else begin
          shadow_kind[c.slot] = (c.mode == MODE_SINE) ? KIND_SINE : KIND_SAW;
          shadow_phase[c.slot] = '0;
          shadow_offset[c.slot] = c.shift;
          shadow_ampl[c.slot] = c.ampl;
          shadow_period[c.slot] = c.period;
          refresh_value(c.slot);
        end
      end
      MODE_TICK: begin
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (shadow_used[s]) begin
            sum = {1'b0, shadow_phase[s]} + {1'b0, c.dt};
            if (shadow_period[s] != 0 && sum > {1'b0, shadow_period[s]}) begin
              sum = sum % {1'b0, shadow_period[s]};
              if (sum == 0) sum = {1'b0, shadow_period[s]};
            end
            shadow_phase[s] = sum[31:0];
            refresh_value(s);
          end
        end
      end
      MODE_READ: begin
        if (!ok) a.status = ST_BAD;
        else a.wave = shadow_value[c.slot];
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic command_t make_cmd(logic [2:0] m, logic [7:0] s, logic [31:0] sh,
                                        logic [31:0] am, logic [31:0] pe, logic [31:0] d);
    command_t c;
    c = '{m, s, sh, am, pe, d};
    return c;
  endfunction

  // Random play with mostly small periods so ticks wrap often.
  function automatic command_t random_play(logic [7:0] s);
    logic [31:0] pe;
    case ($urandom_range(0, 3))
      0: pe = $urandom_range(1, 1024);
      1: pe = $urandom_range(1, 32'h0010_0000);
      2: pe = $urandom();
      default: pe = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 32'h0004_0000);
    endcase
    return make_cmd($urandom_range(0, 1) ? MODE_SINE : MODE_SAW, s, $urandom(), $urandom(),
                    pe, $urandom());
  endfunction

  function automatic logic [31:0] random_dt();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4096);
      1: return $urandom_range(0, 32'h0008_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random_phase(int unsigned count);
    logic [7:0] s;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      s = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, SLOTS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 22) pending_cmds.push_back(make_cmd(MODE_ALLOC, $urandom(), $urandom(),
                                                     $urandom(), $urandom(), $urandom()));
      else if (pick < 34) pending_cmds.push_back(make_cmd(MODE_FREE, s, $urandom(),
                                                          $urandom(), $urandom(), $urandom()));
      else if (pick < 56) pending_cmds.push_back(random_play(s));
      else if (pick < 68) pending_cmds.push_back(make_cmd(MODE_TICK, $urandom(), $urandom(),
                                                          $urandom(), $urandom(), random_dt()));
      else if (pick < 95) pending_cmds.push_back(make_cmd(MODE_READ, s, $urandom(), $urandom(),
                                                          $urandom(), $urandom()));
      else pending_cmds.push_back(make_cmd(3'($urandom_range(6, 7)), $urandom(), $urandom(),
                                           $urandom(), $urandom(), $urandom()));
    end
  endtask

  // Stimulus: directed cases first, then random phases with the two pressure points.
  initial begin
    pool_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes of every field, every mode, and the special cases.
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, '1, '1, '1, '1, '1));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, '0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_SINE, 8'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h0001_0000, '0));
    pending_cmds.push_back(make_cmd(MODE_SAW, 8'd1, 32'h8000_0000, 32'h8000_0000,
                                    32'hffff_ffff, '0));
    pending_cmds.push_back(make_cmd(MODE_TICK, '0, '0, '0, '0, 32'h0000_4000));
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd1, '0, '0, '0, '0));
    // Phase lands exactly on a multiple of the period: wraps to the period itself.
    pending_cmds.push_back(make_cmd(MODE_TICK, '0, '0, '0, '0, 32'h0002_c000));
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd0, '0, '0, '0, '0));
    // Zero period: value is the offset, phase wraps modulo 2^32.
    pending_cmds.push_back(make_cmd(MODE_SAW, 8'd1, 32'h1234_5678, 32'h7fff_ffff, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_TICK, '0, '0, '0, '0, 32'hffff_ffff));
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd1, '0, '0, '0, '0));
    // Out-of-range slot for free, play and read; free of an unused slot.
    pending_cmds.push_back(make_cmd(MODE_FREE, 8'd255, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_SINE, 8'd64, '1, '1, '1, '0));
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd200, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_FREE, 8'd5, '0, '0, '0, '0));
    // Play on an unused slot: never ticked, readable.
    pending_cmds.push_back(make_cmd(MODE_SINE, 8'd63, 32'h0001_0000, 32'h8000_0000,
                                    32'h0000_0003, '0));
    pending_cmds.push_back(make_cmd(MODE_READ, 8'd63, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_FREE, 8'd1, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, '0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(3'd6, '1, '1, '1, '1, '1));
    pending_cmds.push_back(make_cmd(3'd7, '0, '0, '0, '0, '0));
    // Drain the stack to reach the empty case.
    for (int n = 0; n < SLOTS; n++)
      pending_cmds.push_back(make_cmd(MODE_ALLOC, '0, '0, '0, '0, '0));

    queue_random_phase(40);
    // The receiver holds off while commands keep arriving, so the block backs up.
    wait (pending_cmds.size() == 0);
    hold_receiver = 1'b1;
    queue_random_phase(10);
    wait (pending_cmds.size() == 0);
    queue_random_phase(50);
    // The sender pauses until every expected answer has come back.
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_answers.size() == 0);
    queue_random_phase(50);
    wait (pending_cmds.size() == 0);
    stimulus_done = 1'b1;
  end

  // Driver: draws a gap before each command and holds the payload while stalled.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(pool_apply('{mode, slot_index, shift_in, ampl_in,
                                                period_in, dt}));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          command_t c;
          c = pending_cmds.pop_front();
          mode <= c.mode;
          slot_index <= c.slot;
          shift_in <= c.shift;
          ampl_in <= c.ampl;
          period_in <= c.period;
          dt <= c.dt;
          in_valid <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each transfer and draws the next stall length. A long hold-off
  // is counted here when the stimulus asks for one.
  int unsigned recv_wait = 0;
  int unsigned hold_cycles = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected transfer status=%0d granted=%0d wave=%h",
                   $time, status, granted_slot, wave_value);
          error_count++;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            error_count++;
          end
          if (granted_slot !== e.granted) begin
            $display("%0t: granted_slot expected %0d actual %0d", $time, e.granted,
                     granted_slot);
            error_count++;
          end
          if (wave_value !== e.wave) begin
            $display("%0t: wave_value expected %h actual %h", $time, e.wave, wave_value);
            error_count++;
          end
        end
        recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else if (hold_receiver && !hold_taken) begin
        out_stall <= 1'b1;
        if (hold_cycles == 3000) hold_taken <= 1'b1;
        hold_cycles <= hold_cycles + 1;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer, and the end of the run.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    @(posedge clk);
    wait (!in_valid && expected_answers.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
